// ===== hw/rtl/drpi_pkg.sv =====
// Shared types, constants and helper functions of the pose integrator.
package drpi_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ODO_W      = 32;
    localparam int POS_W      = 48;
    localparam int DIST_LIM_W = 31;
    localparam int YAW_LIM_W  = 15;
    localparam int CFG_W      = 31;
    localparam int CS_W       = 34;
    localparam int Q15_W      = 16;
    localparam int PROD_W     = ODO_W + Q15_W;

    localparam logic [DIST_LIM_W-1:0] MAX_DISTANCE_RST = DIST_LIM_W'(32768);
    localparam logic [YAW_LIM_W-1:0]  MAX_YAW_RST      = YAW_LIM_W'(15646);

    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = CS_W'(652032874);

    localparam logic [0:0] CFG_MAX_DISTANCE = 1'b0;
    localparam logic [0:0] CFG_MAX_YAW      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_HEAD,
        ST_START,
        ST_ROTATE,
        ST_MUL_COS,
        ST_ADD_X,
        ST_DONE
    } drpi_state_t;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10680862;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Q4.30 to Q1.15 with round half up and clamping.
    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CS_W-1:0] v);
        logic signed [CS_W-1:0] rnd;
        logic signed [CS_W-1:0] sh;
        logic signed [Q15_W-1:0] r;
        rnd = v + CS_W'(16384);
        sh  = rnd >>> 15;
        if (sh > CS_W'(32767))
            r = 16'sh7FFF;
        else if (sh < -CS_W'(32768))
            r = 16'sh8000;
        else
            r = sh[Q15_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/drpi_cordic.sv =====
// Iterative CORDIC rotator giving cosine and sine of a binary angle in Q1.15.
module drpi_cordic
    import drpi_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ANGLE_BITS-1:0]          angle,
    output logic                           done,
    output logic signed [Q15_W-1:0]        cos_q15,
    output logic signed [Q15_W-1:0]        sin_q15
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    logic signed [CS_W-1:0] x_reg, x_next;
    logic signed [CS_W-1:0] y_reg, y_next;
    logic [31:0]            z_reg, z_next;
    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg;
    logic                   fin_reg;
    logic                   done_reg;
    logic signed [Q15_W-1:0] cos_reg;
    logic signed [Q15_W-1:0] sin_reg;

    logic [31:0]            z_start;
    logic signed [CS_W-1:0] xs, ys;
    logic [31:0]            atan_val;

    assign z_start  = {angle, {(32-ANGLE_BITS){1'b0}}};
    assign xs       = x_reg >>> step_reg;
    assign ys       = y_reg >>> step_reg;
    assign atan_val = atan_entry(5'(step_reg));

    always_comb
    begin
        if (!z_reg[31])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
            if (fin_reg)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // Angles in the left half plane start from the negated vector.
            if (z_start > 32'h4000_0000 && z_start < 32'hC000_0000)
            begin
                z_reg <= z_start + 32'h8000_0000;
                x_reg <= -CORDIC_GAIN_Q30;
            end
            else
            begin
                z_reg <= z_start;
                x_reg <= CORDIC_GAIN_Q30;
            end
            y_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (fin_reg)
        begin
            cos_reg <= to_q15(x_reg);
            sin_reg <= to_q15(y_reg);
        end
    end

    assign done    = done_reg;
    assign cos_q15 = cos_reg;
    assign sin_q15 = sin_reg;

endmodule

// ===== hw/rtl/dead_reckoning_pose_integrator_unit.sv =====
// Top level of the dead-reckoning pose integrator.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid / in_ready       odo_reading, imu_yaw
//   out       output     out_valid / out_ready     pose_x, pose_y, pose_heading
//   cfg       input      cfg_write_en              cfg_index, cfg_data
//
// A transaction passes through the states STEP, HEAD, START, ROTATE, MUL_COS, ADD_X and
// DONE on its way from acceptance to the result register; the iterative CORDIC rotator,
// one rotation per cycle, takes most of that time, and one shared multiplier serves x and y.
// A new input is taken only in the idle state, so the unit accepts no input while it
// works on the last one; a finished result waits in the output register
// while the next input is accepted and worked on, and a result that finds that
// register still full holds the unit in its final state.
// Reset clears the pose, the previous readings and restores the limit registers.
module dead_reckoning_pose_integrator_unit
    import drpi_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [ODO_W-1:0]        odo_reading,
    input  logic [ANGLE_BITS-1:0]          imu_yaw,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [POS_W-1:0]        pose_x,
    output logic signed [POS_W-1:0]        pose_y,
    output logic [ANGLE_BITS-1:0]          pose_heading,
    input  logic                           cfg_write_en,
    input  logic [0:0]                     cfg_index,
    input  logic [CFG_W-1:0]               cfg_data
);

    localparam int DS_W = ODO_W + 2;
    localparam int DY_W = (ANGLE_BITS > YAW_LIM_W ? ANGLE_BITS : YAW_LIM_W) + 2;

    drpi_state_t state_reg, state_next;

    logic [DIST_LIM_W-1:0]        max_distance_reg;
    logic [YAW_LIM_W-1:0]         max_yaw_reg;

    logic signed [ODO_W-1:0]      odo_in_reg;
    logic [ANGLE_BITS-1:0]        yaw_in_reg;
    logic signed [ODO_W-1:0]      last_odo_reg;
    logic [ANGLE_BITS-1:0]        last_yaw_reg;
    logic signed [ODO_W-1:0]      ds_reg;
    logic [ANGLE_BITS-1:0]        dyaw_reg;
    logic [ANGLE_BITS-1:0]        heading_reg;
    logic signed [POS_W-1:0]      pos_x_reg;
    logic signed [POS_W-1:0]      pos_y_reg;
    logic signed [PROD_W-1:0]     prod_reg;

    logic                         out_valid_reg;
    logic signed [POS_W-1:0]      out_x_reg;
    logic signed [POS_W-1:0]      out_y_reg;
    logic [ANGLE_BITS-1:0]        out_heading_reg;

    logic                         cordic_start;
    logic                         cordic_done;
    logic signed [Q15_W-1:0]      cos_q15;
    logic signed [Q15_W-1:0]      sin_q15;

    logic signed [DS_W-1:0]       ds_full;
    logic signed [DS_W-1:0]       lim_s;
    logic                         ds_ok;
    logic [ANGLE_BITS-1:0]        yaw_diff;
    logic signed [DY_W-1:0]       dyaw_ext;
    logic signed [DY_W-1:0]       lim_y;
    logic                         dyaw_ok;

    logic signed [Q15_W-1:0]      mul_b;
    logic signed [POS_W:0]        rnd;
    logic signed [POS_W:0]        inc;
    logic signed [POS_W-1:0]      pos_sel;
    logic signed [POS_W:0]        pos_sum;
    logic signed [POS_W-1:0]      pos_sat;
    logic                         out_free;

    drpi_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (heading_reg),
        .done    (cordic_done),
        .cos_q15 (cos_q15),
        .sin_q15 (sin_q15)
    );

    // Step limiting: both steps must lie strictly inside their symmetric limit.
    assign ds_full  = DS_W'(odo_in_reg) - DS_W'(last_odo_reg);
    assign lim_s    = DS_W'({1'b0, max_distance_reg});
    assign ds_ok    = (ds_full > -lim_s) && (ds_full < lim_s);
    assign yaw_diff = yaw_in_reg - last_yaw_reg;
    assign dyaw_ext = DY_W'($signed(yaw_diff));
    assign lim_y    = DY_W'({1'b0, max_yaw_reg});
    assign dyaw_ok  = (dyaw_ext > -lim_y) && (dyaw_ext < lim_y);

    // Shared position update: round the product, add and saturate.
    assign mul_b    = (state_reg == ST_MUL_COS) ? cos_q15 : sin_q15;
    assign rnd      = (POS_W+1)'(prod_reg) + (POS_W+1)'(16384);
    assign inc      = rnd >>> 15;
    assign pos_sel  = (state_reg == ST_ADD_X) ? pos_x_reg : pos_y_reg;
    assign pos_sum  = (POS_W+1)'(pos_sel) + inc;

    always_comb
    begin
        if (pos_sum[POS_W] != pos_sum[POS_W-1])
            pos_sat = pos_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                     : {1'b0, {(POS_W-1){1'b1}}};
        else
            pos_sat = pos_sum[POS_W-1:0];
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_STEP;
            ST_STEP:    state_next = ST_HEAD;
            ST_HEAD:    state_next = ST_START;
            ST_START:   state_next = ST_ROTATE;
            ST_ROTATE:  if (cordic_done) state_next = ST_MUL_COS;
            ST_MUL_COS: state_next = ST_ADD_X;
            ST_ADD_X:   state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cordic_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready     = 1'b1;
            ST_START: cordic_start = 1'b1;
            ST_STEP, ST_HEAD, ST_ROTATE, ST_MUL_COS, ST_ADD_X, ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            max_distance_reg <= MAX_DISTANCE_RST;
            max_yaw_reg      <= MAX_YAW_RST;
            last_odo_reg     <= '0;
            last_yaw_reg     <= '0;
            heading_reg      <= '0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_MAX_DISTANCE: max_distance_reg <= cfg_data[DIST_LIM_W-1:0];
                    CFG_MAX_YAW:      max_yaw_reg      <= cfg_data[YAW_LIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_STEP)
            begin
                // Readings are kept whether or not their steps pass the limits.
                last_odo_reg <= odo_in_reg;
                last_yaw_reg <= yaw_in_reg;
            end
            if (state_reg == ST_HEAD)
                heading_reg <= heading_reg + dyaw_reg;
            if (state_reg == ST_ADD_X)
                pos_x_reg <= pos_sat;
            if (state_reg == ST_DONE && out_free)
                pos_y_reg <= pos_sat;

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            odo_in_reg <= odo_reading;
            yaw_in_reg <= imu_yaw;
        end
        if (state_reg == ST_STEP)
        begin
            ds_reg   <= ds_ok ? ds_full[ODO_W-1:0] : '0;
            dyaw_reg <= dyaw_ok ? yaw_diff : '0;
        end
        if (state_reg == ST_MUL_COS || state_reg == ST_ADD_X)
            prod_reg <= ds_reg * mul_b;
        if (state_reg == ST_DONE && out_free)
        begin
            out_x_reg       <= pos_x_reg;
            out_y_reg       <= pos_sat;
            out_heading_reg <= heading_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pose_x       = out_x_reg;
    assign pose_y       = out_y_reg;
    assign pose_heading = out_heading_reg;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the dead-reckoning pose integrator with its own pose predictor.
`timescale 1ns / 100ps

module tb_top;
    import drpi_pkg::*;

    localparam int AW           = ANGLE_BITS_DEF;
    localparam int DRAIN_CYCLES = CORDIC_STEPS_DEF + 16;
    localparam int CYCLE_LIMIT  = 12_000_000;
    localparam longint POS_HI   = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_LO   = -POS_HI - 1;

    // Arctangent of 2^-i, 2^32 units per turn.
    localparam logic [0:15][31:0] ATAN_TURN = {
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef struct packed {
        logic [ODO_W-1:0] odo;
        logic [AW-1:0]    yaw;
    } sample_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [AW-1:0]    heading;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [ODO_W-1:0] odo_reading = '0;
    logic [AW-1:0]           imu_yaw = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic [AW-1:0]           pose_heading;
    logic                    cfg_write_en = 1'b0;
    logic [0:0]              cfg_index = CFG_MAX_DISTANCE;
    logic [CFG_W-1:0]        cfg_data = '0;

    // Predictor state and its copy of the limit registers.
    logic [DIST_LIM_W-1:0]   lim_dist = MAX_DISTANCE_RST;
    logic [YAW_LIM_W-1:0]    lim_yaw = MAX_YAW_RST;
    logic signed [ODO_W-1:0] prev_odo = '0;
    logic [AW-1:0]           prev_yaw = '0;
    logic [AW-1:0]           est_heading = '0;
    longint                  est_x = 0;
    longint                  est_y = 0;

    // Last readings queued by the stimulus, so that steps can be made relative.
    logic signed [ODO_W-1:0] gen_odo = '0;
    logic [AW-1:0]           gen_yaw = '0;

    sample_t sample_queue[$];
    pose_t   pose_expect[$];

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic steady = 1'b0;
    logic calm = 1'b0;
    int   calm_left = 0;
    int   in_gap = 0;
    int   stall_left = 2;
    int   cycle_count = 0;
    int   mismatches = 0;

    dead_reckoning_pose_integrator_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .odo_reading       (odo_reading),
        .imu_yaw           (imu_yaw),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pose_x            (pose_x),
        .pose_y            (pose_y),
        .pose_heading      (pose_heading),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int draw_gap();
        if (steady || calm)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    function automatic logic signed [Q15_W-1:0] round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return r[Q15_W-1:0];
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI)
            return POS_HI;
        if (v < POS_LO)
            return POS_LO;
        return v;
    endfunction

    // Advances the predicted pose by one sensor sample and queues the expected result.
    function automatic void advance_pose(input logic signed [ODO_W-1:0] odo,
                                         input logic [AW-1:0] yaw);
        logic [AW-1:0]           yaw_diff;
        logic [31:0]             z;
        longint                  travel;
        longint                  turn;
        longint                  vx;
        longint                  vy;
        longint                  xs;
        longint                  ys;
        logic signed [Q15_W-1:0] cos_q;
        logic signed [Q15_W-1:0] sin_q;
        pose_t                   p;
        travel = longint'(odo) - longint'(prev_odo);
        yaw_diff = yaw - prev_yaw;
        turn = longint'($signed(yaw_diff));
        if (!(-longint'(lim_dist) < travel && travel < longint'(lim_dist)))
            travel = 0;
        if (!(-longint'(lim_yaw) < turn && turn < longint'(lim_yaw)))
            turn = 0;
        est_heading = est_heading + turn[AW-1:0];

        z = 32'(est_heading) << (32 - AW);
        vx = longint'(CORDIC_GAIN_Q30);
        vy = 0;
        // Angles in the left half plane start from the negated vector.
        if (z > 32'h4000_0000 && z < 32'hC000_0000)
        begin
            z = z + 32'h8000_0000;
            vx = -vx;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (!z[31])
            begin
                vx = vx - ys;
                vy = vy + xs;
                z = z - ATAN_TURN[i];
            end
            else
            begin
                vx = vx + ys;
                vy = vy - xs;
                z = z + ATAN_TURN[i];
            end
        end
        cos_q = round_q15(vx);
        sin_q = round_q15(vy);
        est_x = clamp_pos(est_x + ((travel * longint'(cos_q) + 16384) >>> 15));
        est_y = clamp_pos(est_y + ((travel * longint'(sin_q) + 16384) >>> 15));

        prev_odo = odo;
        prev_yaw = yaw;
        p.x = est_x[POS_W-1:0];
        p.y = est_y[POS_W-1:0];
        p.heading = est_heading;
        pose_expect.push_back(p);
    endfunction

    function automatic void push_sample(input longint odo_val, input longint yaw_val);
        sample_t s;
        s.odo = odo_val[ODO_W-1:0];
        s.yaw = yaw_val[AW-1:0];
        gen_odo = s.odo;
        gen_yaw = s.yaw;
        sample_queue.push_back(s);
    endfunction

    // Mostly plausible motion within the limits, some steps on the limits, some noise.
    task automatic queue_random_samples(input int count);
        longint lim_s;
        longint lim_y;
        longint cap;
        longint step_s;
        longint step_y;
        int     pick;
        for (int n = 0; n < count; n++)
        begin
            lim_s = longint'(lim_dist);
            lim_y = longint'(lim_yaw);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 3) == 0 || lim_s < 262144)
                    cap = lim_s;
                else
                    cap = 262144;
                step_s = (cap > 1) ? longint'($urandom_range(0, 32'(cap - 1))) : 0;
                step_y = (lim_y > 1) ? longint'($urandom_range(0, 32'(lim_y - 1))) : 0;
                if ($urandom_range(0, 1))
                    step_s = -step_s;
                if ($urandom_range(0, 1))
                    step_y = -step_y;
                push_sample(gen_odo + step_s, gen_yaw + step_y);
            end
            else if (pick < 85)
            begin
                step_s = lim_s - longint'($urandom_range(0, 1));
                case ($urandom_range(0, 2))
                    0:       step_y = lim_y;
                    1:       step_y = lim_y - 1;
                    default: step_y = -32768;
                endcase
                if ($urandom_range(0, 1))
                    step_s = -step_s;
                if ($urandom_range(0, 1))
                    step_y = -step_y;
                push_sample(gen_odo + step_s, gen_yaw + step_y);
            end
            else
            begin
                push_sample(longint'($signed($urandom())), longint'($urandom_range(0, 65535)));
            end
        end
    endtask

    task automatic write_limit(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_MAX_DISTANCE)
            lim_dist = value[DIST_LIM_W-1:0];
        else
            lim_yaw = value[YAW_LIM_W-1:0];
        @(posedge clk);
    endtask

    task automatic drain();
        while (sample_queue.size() != 0 || in_valid || pose_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] dist_val,
                             input logic [CFG_W-1:0] yaw_val,
                             input int count);
        write_limit(CFG_MAX_DISTANCE, dist_val);
        write_limit(CFG_MAX_YAW, yaw_val);
        queue_random_samples(count);
        drain();
    endtask

    // Input side: one transaction per queued sample, with a random gap after each.
    always @(negedge clk)
    begin : sample_driver
        sample_t s;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (sample_queue.size() != 0)
            begin
                s = sample_queue.pop_front();
                in_valid <= 1'b1;
                odo_reading <= s.odo;
                imu_yaw <= s.yaw;
                in_gap <= draw_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            advance_pose(odo_reading, imu_yaw);
    end

    // Output side: after each transaction, ready drops for a randomly drawn wait, which may be zero.
    always @(negedge clk)
    begin : ready_driver
        int ready_wait;
        if (rst_n)
        begin
            if (out_fire)
            begin
                ready_wait = draw_gap();
                stall_left <= ready_wait;
                out_ready <= (ready_wait == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= (stall_left == 1);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        pose_t want;
        out_fire <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_expect.size() == 0)
            begin
                $error("pose result with no expectation: x %0d y %0d heading %0d",
                       pose_x, pose_y, pose_heading);
                mismatches++;
            end
            else
            begin
                want = pose_expect.pop_front();
                if (pose_x !== want.x)
                begin
                    $error("pose_x: expected %0d, actual %0d", $signed(want.x), pose_x);
                    mismatches++;
                end
                if (pose_y !== want.y)
                begin
                    $error("pose_y: expected %0d, actual %0d", $signed(want.y), pose_y);
                    mismatches++;
                end
                if (pose_heading !== want.heading)
                begin
                    $error("pose_heading: expected %0d, actual %0d", want.heading, pose_heading);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog, and random stretches in which neither side idles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (calm_left == 0)
        begin
            calm <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(50, 400);
        end
        else
            calm_left <= calm_left - 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("dead_reckoning_pose_integrator_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first sample is measured from zero readings; then the heading
        // walks through every eighth of a turn while moving.
        push_sample(32'sh4000, 0);
        for (int k = 1; k <= 7; k++)
            push_sample(gen_odo + 32'sh4000, k * 8192);
        // Distance steps on and just inside the limit, both signs.
        push_sample(gen_odo + 32768, gen_yaw);
        push_sample(gen_odo + 32767, gen_yaw);
        push_sample(gen_odo - 32768, gen_yaw);
        push_sample(gen_odo - 32767, gen_yaw);
        // Yaw steps on and just inside the limit, then exactly half a turn back.
        push_sample(gen_odo, gen_yaw + 15645);
        push_sample(gen_odo, gen_yaw + 15646);
        push_sample(gen_odo, gen_yaw - 15645);
        push_sample(gen_odo, gen_yaw - 15646);
        push_sample(gen_odo, gen_yaw + 32768);
        push_sample(64'sd2147483647, 16'hFFFF);
        push_sample(-64'sd2147483648, 16'h0000);
        drain();

        // With zero limits even a zero step counts as rejected.
        write_limit(CFG_MAX_DISTANCE, '0);
        write_limit(CFG_MAX_YAW, '0);
        push_sample(gen_odo, gen_yaw);
        push_sample(gen_odo + 1, gen_yaw + 1);
        drain();

        // Full-size steps forward at heading zero, then backward at nearly
        // half a turn, back to back.
        write_limit(CFG_MAX_DISTANCE, '1);
        write_limit(CFG_MAX_YAW, '1);
        steady = 1'b1;
        for (int k = 0; k < 20; k++)
        begin
            push_sample(64'sd1073741823, 0);
            push_sample(-64'sd1073741823, 32766);
        end
        push_sample(64'sd1073741823, 0);
        push_sample(-64'sd1073741823, 0);
        push_sample(64'sd1073741823, 0);
        drain();
        steady = 1'b0;

        run_phase(CFG_W'(MAX_DISTANCE_RST), CFG_W'(MAX_YAW_RST), 260);
        run_phase('1, '1, 240);
        run_phase(CFG_W'($urandom_range(1, 2000)), CFG_W'($urandom_range(1, 200)), 240);
        run_phase(CFG_W'($urandom()), CFG_W'($urandom()), 240);
        run_phase('0, '0, 160);
        run_phase(CFG_W'(1), CFG_W'(1), 100);
        run_phase(CFG_W'($urandom_range(16384, 1 << 20)), CFG_W'($urandom_range(1000, 32767)),
                  210);

        if (mismatches == 0)
            $display("dead_reckoning_pose_integrator_unit regression: pass");
        else
            $display("dead_reckoning_pose_integrator_unit regression: fail");
        $finish;
    end

endmodule
